FILE: rtl/rice_bit_packer_core_defines.svh
// Assertion macros for the rice bit packer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RICE_BIT_PACKER_CORE_DEFINES_SVH
`define RICE_BIT_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rice bit packer check failed");

// Next-cycle implication, disabled during reset.
`define RBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rice bit packer check failed");

`endif

FILE: rtl/rbp_pkg.sv
// Shared types and constants for the rice bit packer.
// No dependencies; used by the bit source, byte packer and top level.
package rbp_pkg;

   localparam int MAX_UNARY = 255;
   localparam int DATA_W    = 64;
   localparam int RICE_W    = 32;
   localparam int UNARY_W   = $clog2(MAX_UNARY + 1);
   localparam int REMAIN_W  = $clog2(MAX_UNARY + DATA_W + 2);
   localparam int BYTE_W    = 8;
   localparam int WBYTES    = 8;

   typedef enum logic [2:0] {
      CMD_BITS  = 3'd0,
      CMD_UNARY = 3'd1,
      CMD_RICE  = 3'd2,
      CMD_WORD  = 3'd3,
      CMD_FLUSH = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORD,
      ST_FLUSH,
      ST_ERROR
   } state_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_BYTE,
      OP_FLUSH
   } op_kind_type;

   // Job handed to the bit source: unary zeros, optional stop one, then bits
   typedef struct packed {
      logic               valid;
      logic [UNARY_W-1:0] zeros;
      logic               unary;
      logic [DATA_W-1:0]  data;   // left-aligned, earliest bit in the MSB
      logic [6:0]         nbits;
   } src_load_type;

   // One step for the byte packer
   typedef struct packed {
      logic              valid;
      op_kind_type       kind;
      logic              bit_val;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              error;
   } pack_op_type;

endpackage

FILE: rtl/rbp_bit_source.sv
// Bit source of the rice bit packer: serializes unary runs and data bits.
// Depends on rbp_pkg.
module rbp_bit_source (
   input  logic                 clock,
   input  logic                 reset,
   input  rbp_pkg::src_load_type load,
   input  logic                 step,
   output logic                 busy,
   output logic                 bit_val,
   output logic                 last
);

   logic [rbp_pkg::UNARY_W-1:0]  zeros_ff, zeros_in;
   logic                         one_ff, one_in;
   logic [rbp_pkg::DATA_W-1:0]   data_ff, data_in;
   logic [rbp_pkg::REMAIN_W-1:0] remain_ff, remain_in;
   logic                         busy_ff, busy_in;

   assign busy    = busy_ff;
   assign bit_val = (zeros_ff != '0) ? 1'b0 : (one_ff ? 1'b1 : data_ff[rbp_pkg::DATA_W-1]);
   // another byte can only follow if eight more bits remain after this one
   assign last    = remain_ff <= rbp_pkg::REMAIN_W'(rbp_pkg::BYTE_W);

   always_comb begin
      zeros_in  = zeros_ff;
      one_in    = one_ff;
      data_in   = data_ff;
      remain_in = remain_ff;
      busy_in   = busy_ff;
      if (load.valid) begin
         zeros_in  = load.zeros;
         one_in    = load.unary;
         data_in   = load.data;
         remain_in = rbp_pkg::REMAIN_W'(load.zeros) + rbp_pkg::REMAIN_W'(load.unary)
                     + rbp_pkg::REMAIN_W'(load.nbits);
         busy_in   = 1'b1;
      end else if (busy_ff && step) begin
         if (zeros_ff != '0) begin
            zeros_in = zeros_ff - rbp_pkg::UNARY_W'(1);
         end else if (one_ff) begin
            one_in = 1'b0;
         end else begin
            data_in = {data_ff[rbp_pkg::DATA_W-2:0], 1'b0};
         end
         remain_in = remain_ff - rbp_pkg::REMAIN_W'(1);
         busy_in   = remain_ff != rbp_pkg::REMAIN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      zeros_ff  <= zeros_in;
      one_ff    <= one_in;
      data_ff   <= data_in;
      remain_ff <= remain_in;
   end

endmodule

FILE: rtl/rbp_byte_packer.sv
// Byte packer of the rice bit packer: gathers bits into bytes, holds the result register.
// Depends on rbp_pkg.
module rbp_byte_packer (
   input  logic                clock,
   input  logic                reset,
   input  rbp_pkg::pack_op_type op,
   output logic                op_ready,
   output logic [2:0]          bit_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last,
   output logic                rsp_error
);

   logic [6:0] partial_ff, partial_in;
   logic [2:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       error_ff, error_in;
   logic       needs_out, out_free, fire;
   logic [7:0] emit_byte;

   assign out_free  = !valid_ff || rsp_ready;
   assign op_ready  = !needs_out || out_free;
   assign fire      = op.valid && op_ready;
   assign bit_count = count_ff;

   always_comb begin
      unique case (op.kind)
         rbp_pkg::OP_PUSH: begin
            needs_out = count_ff == 3'd7;
            emit_byte = {partial_ff, op.bit_val};
         end
         rbp_pkg::OP_BYTE: begin
            needs_out = 1'b1;
            emit_byte = op.data;
         end
         rbp_pkg::OP_FLUSH: begin
            needs_out = count_ff != 3'd0;
            emit_byte = 8'({1'b0, partial_ff} << (4'd8 - {1'b0, count_ff}));
         end
         default: begin
            needs_out = 1'b0;
            emit_byte = '0;
         end
      endcase
   end

   always_comb begin
      partial_in = partial_ff;
      count_in   = count_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      last_in    = last_ff;
      error_in   = error_ff;
      if (fire) begin
         if (op.kind == rbp_pkg::OP_PUSH) begin
            if (count_ff == 3'd7) begin
               partial_in = '0;
               count_in   = '0;
            end else begin
               partial_in = {partial_ff[5:0], op.bit_val};
               count_in   = count_ff + 3'd1;
            end
         end else if (op.kind == rbp_pkg::OP_FLUSH) begin
            partial_in = '0;
            count_in   = '0;
         end
         if (needs_out) begin
            valid_in = 1'b1;
            byte_in  = emit_byte;
            last_in  = op.last;
            error_in = op.error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

endmodule

FILE: rtl/rice_bit_packer_core.sv
// Top level of the rice bit packer: command decode, word and flush sequencing.
// Depends on rbp_pkg, rbp_bit_source and rbp_byte_packer.
//
// MSB-first bit packer. Each accepted command writes bits into a running byte,
// earliest bit in bit 7, and every byte that fills is presented on the rsp_
// channel at once, with rsp_last on the final byte caused by that command.
// Commands: write bits (low width bits of value, width clamped to 64), write
// unary (value zeros then a one), write rice (zigzag of value[31:0], quotient
// in unary, then rem_bits remainder bits), write word (1 to 8 bytes of value
// little-endian, only at a byte boundary) and flush (partial byte, left-
// justified and zero padded). A unary count or rice quotient above MAX_UNARY,
// or a word write off a byte boundary, writes nothing and returns a single
// zero byte with rsp_error and rsp_last set. Bits travel one per cycle through
// a shift register, while the byte packer can take them, so a bit, unary or
// rice command holds the block until its bits (rice: quotient + 1 + rem_bits)
// have been shifted out; a word write sends its bytes in turn. A stalled rsp_
// channel holds the bit path only when a finished byte has nowhere to go. A
// new command is taken once the previous one has produced all its bytes; its
// last byte may still wait in the output register.
module rice_bit_packer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_value,
   input  logic [6:0]  req_width,
   input  logic [4:0]  req_rem_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_error
);

   rbp_pkg::state_type     state_ff, state_in;
   logic [63:0]            word_ff, word_in;
   logic [3:0]             left_ff, left_in;

   rbp_pkg::src_load_type  load;
   rbp_pkg::pack_op_type   op;
   logic                   src_busy, src_bit, src_last;
   logic                   op_ready;
   logic [2:0]             bit_count;
   logic                   accept;

   // rice front end: zigzag map and quotient
   logic [rbp_pkg::RICE_W-1:0] zig, quot;
   logic [6:0]                 nbits_clamp;
   logic [3:0]                 nbytes_clamp;
   logic                       rice_over, unary_over;

   assign req_ready = (state_ff == rbp_pkg::ST_IDLE) && !src_busy;
   assign accept    = req_valid && req_ready;

   assign zig  = {req_value[30:0], 1'b0} ^ {rbp_pkg::RICE_W{req_value[31]}};
   assign quot = zig >> req_rem_bits;
   assign rice_over  = quot > rbp_pkg::RICE_W'(rbp_pkg::MAX_UNARY);
   assign unary_over = req_value > rbp_pkg::DATA_W'(rbp_pkg::MAX_UNARY);
   assign nbits_clamp  = (req_width > 7'd64) ? 7'd64 : req_width;
   assign nbytes_clamp = (req_width > 7'(rbp_pkg::WBYTES)) ? 4'(rbp_pkg::WBYTES)
                                                           : req_width[3:0];

   // Decode the command and step the word / flush / error sequencer
   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      left_in    = left_ff;
      load       = '0;
      if (accept) begin
         unique case (req_cmd)
            rbp_pkg::CMD_BITS: begin
               load.valid = nbits_clamp != 7'd0;
               load.nbits = nbits_clamp;
               load.data  = req_value << (7'd64 - nbits_clamp);
            end
            rbp_pkg::CMD_UNARY: begin
               if (unary_over) begin
                  state_in = rbp_pkg::ST_ERROR;
               end else begin
                  load.valid = 1'b1;
                  load.zeros = req_value[rbp_pkg::UNARY_W-1:0];
                  load.unary = 1'b1;
               end
            end
            rbp_pkg::CMD_RICE: begin
               if (rice_over) begin
                  state_in = rbp_pkg::ST_ERROR;
               end else begin
                  load.valid = 1'b1;
                  load.zeros = quot[rbp_pkg::UNARY_W-1:0];
                  load.unary = 1'b1;
                  load.nbits = {2'b00, req_rem_bits};
                  // left-align the remainder: low rem_bits bits of zig
                  load.data  = {zig, 32'd0} << (7'd32 - {2'b00, req_rem_bits});
               end
            end
            rbp_pkg::CMD_WORD: begin
               if (bit_count != 3'd0) begin
                  state_in = rbp_pkg::ST_ERROR;
               end else if (nbytes_clamp != 4'd0) begin
                  state_in = rbp_pkg::ST_WORD;
                  word_in  = req_value;
                  left_in  = nbytes_clamp;
               end
            end
            rbp_pkg::CMD_FLUSH: begin
               if (bit_count != 3'd0) begin
                  state_in = rbp_pkg::ST_FLUSH;
               end
            end
            default: begin
               // unused codes: drop the item
            end
         endcase
      end else begin
         unique case (state_ff)
            rbp_pkg::ST_WORD: begin
               if (op_ready) begin
                  word_in = word_ff >> 8;
                  left_in = left_ff - 4'd1;
                  if (left_ff == 4'd1) begin
                     state_in = rbp_pkg::ST_IDLE;
                  end
               end
            end
            rbp_pkg::ST_FLUSH, rbp_pkg::ST_ERROR: begin
               if (op_ready) begin
                  state_in = rbp_pkg::ST_IDLE;
               end
            end
            default: begin
               // idle: hold
            end
         endcase
      end
   end

   // Feed the byte packer from the bit source or the sequencer
   always_comb begin
      op = '0;
      op.kind = rbp_pkg::OP_PUSH;
      if (src_busy) begin
         op.valid   = 1'b1;
         op.bit_val = src_bit;
         op.last    = src_last;
      end else begin
         unique case (state_ff)
            rbp_pkg::ST_WORD: begin
               op.valid = 1'b1;
               op.kind  = rbp_pkg::OP_BYTE;
               op.data  = word_ff[7:0];
               op.last  = left_ff == 4'd1;
            end
            rbp_pkg::ST_FLUSH: begin
               op.valid = 1'b1;
               op.kind  = rbp_pkg::OP_FLUSH;
               op.last  = 1'b1;
            end
            rbp_pkg::ST_ERROR: begin
               op.valid = 1'b1;
               op.kind  = rbp_pkg::OP_BYTE;
               op.last  = 1'b1;
               op.error = 1'b1;
            end
            default: begin
               op.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      word_ff <= word_in;
      left_ff <= left_in;
   end

   rbp_bit_source u_src (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .step    (op_ready),
      .busy    (src_busy),
      .bit_val (src_bit),
      .last    (src_last)
   );

   rbp_byte_packer u_pack (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .op_ready     (op_ready),
      .bit_count    (bit_count),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule

FILE: rtl/rbp_checker.sv
// Port-level checker for the rice bit packer, bound to rice_bit_packer_core.
// Depends on rice_bit_packer_core_defines.svh.
`include "rice_bit_packer_core_defines.svh"

module rbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic        rsp_error
);

   // a stalled result holds
   `RBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte))
   // a rejected item returns exactly one zero byte
   `RBP_ASSERT_NOW(a_err_form, rsp_valid && rsp_error, rsp_last && (rsp_out_byte == 8'd0))
   // while a non-final byte waits, the item is still being packed
   `RBP_ASSERT_NOW(a_busy_mid, rsp_valid && !rsp_last, !req_ready)

endmodule

bind rice_bit_packer_core rbp_checker u_rbp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last),
   .rsp_error    (rsp_error)
);

FILE: tb/rice_bit_packer_core_test.sv
// Self-checking testbench for rice_bit_packer_core: random and directed commands
// against a bit-level packer model. Depends on rbp_pkg and the core RTL only.
module rice_bit_packer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // First command code the block ignores; the two codes above it are ignored too
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'(rbp_pkg::CMD_FLUSH) + 3'd1;

   typedef struct {
      logic [2:0]  cmd;
      logic [63:0] value;
      logic [6:0]  width;
      logic [4:0]  param;
   } pack_cmd_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [63:0] req_value = '0;
   logic [6:0]  req_width = '0;
   logic [4:0]  req_rem_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_error;

   rice_bit_packer_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .req_width    (req_width),
      .req_rem_bits (req_rem_bits),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Packer model: running partial byte, right-justified, and its bit count.
   // Every completed byte is appended to bytes_due in output order.
   // ---------------------------------------------------------------------------
   logic [6:0]   acc_bits = '0;
   logic [2:0]   acc_count = '0;
   out_byte_type bytes_due[$];
   int unsigned  item_bytes;

   pack_cmd_type cmds_pending[$];
   int unsigned  cmds_total = 0;
   int unsigned  items_accepted = 0;
   int unsigned  mismatches = 0;
   int unsigned  send_gap = 0;
   int unsigned  rsp_stall = 0;
   logic         hold_off = 1'b0;

   // Run both sides back to back for a stretch in the middle of the run
   wire quiet = (items_accepted >= 90) && (items_accepted < 125);

   // An error byte is zero with last and error set
   function automatic void emit_byte(logic [7:0] b, logic e);
      out_byte_type ob;
      ob.data = b;
      ob.last = e;
      ob.err  = e;
      bytes_due.push_back(ob);
      item_bytes++;
   endfunction

   // Append one bit; the eighth bit completes a byte
   function automatic void shift_in(logic b);
      if (acc_count == 3'd7) begin
         emit_byte({acc_bits, b}, 1'b0);
         acc_bits  = '0;
         acc_count = '0;
      end else begin
         acc_bits  = {acc_bits[5:0], b};
         acc_count = acc_count + 3'd1;
      end
   endfunction

   // Append the low n bits of v, most significant first
   function automatic void shift_in_bits(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) shift_in(v[i]);
   endfunction

   function automatic void shift_in_unary(int unsigned zeros);
      for (int unsigned i = 0; i < zeros; i++) shift_in(1'b0);
      shift_in(1'b1);
   endfunction

   // Work out every byte one accepted command produces; mark the final one last
   function automatic void pack_command(pack_cmd_type c);
      logic [31:0]  raw;
      logic [31:0]  uval;
      logic [31:0]  quo;
      logic [63:0]  rem;
      int           n;
      out_byte_type tail;
      item_bytes = 0;
      case (c.cmd)
         rbp_pkg::CMD_BITS: begin
            n = (c.width > 7'd64) ? 64 : int'(c.width);
            shift_in_bits(c.value, n);
         end
         rbp_pkg::CMD_UNARY: begin
            if (c.value > 64'(rbp_pkg::MAX_UNARY)) emit_byte(8'h00, 1'b1);
            else shift_in_unary(int'(c.value[31:0]));
         end
         rbp_pkg::CMD_RICE: begin
            // zigzag: 0,-1,1,-2,... map to 0,1,2,3,...
            raw  = c.value[31:0];
            uval = {raw[30:0], 1'b0} ^ {32{raw[31]}};
            quo  = uval >> c.param;
            rem  = {32'd0, uval} & ((64'd1 << c.param) - 64'd1);
            if (quo > 32'(rbp_pkg::MAX_UNARY)) begin
               emit_byte(8'h00, 1'b1);
            end else begin
               shift_in_unary(quo);
               shift_in_bits(rem, int'(c.param));
            end
         end
         rbp_pkg::CMD_WORD: begin
            if (acc_count != 3'd0) begin
               emit_byte(8'h00, 1'b1);
            end else begin
               n = (c.width > 7'd8) ? 8 : int'(c.width);
               for (int i = 0; i < n; i++) emit_byte(c.value[8*i +: 8], 1'b0);
            end
         end
         rbp_pkg::CMD_FLUSH: begin
            // left-justify the partial byte, zero padded
            if (acc_count != 3'd0) begin
               emit_byte(8'({1'b0, acc_bits} << (4'd8 - acc_count)), 1'b0);
               acc_bits  = '0;
               acc_count = '0;
            end
         end
         default: ;
      endcase
      if (item_bytes > 0) begin
         tail = bytes_due.pop_back();
         tail.last = 1'b1;
         bytes_due.push_back(tail);
      end
   endfunction

   function automatic void queue_cmd(logic [2:0] c, logic [63:0] v, logic [6:0] w,
                                     logic [4:0] p);
      pack_cmd_type item;
      item.cmd   = c;
      item.value = v;
      item.width = w;
      item.param = p;
      cmds_pending.push_back(item);
      cmds_total++;
   endfunction

   // Build a rice operand whose quotient is quo (clamped to what fits in 32 bits)
   function automatic logic [63:0] rice_value(int unsigned quo, logic [4:0] p);
      logic [63:0] lim;
      logic [31:0] uval;
      logic [31:0] sval;
      lim = 64'hFFFF_FFFF >> p;
      if (64'(quo) > lim) quo = lim[31:0];
      uval = (32'(quo) << p) | 32'(64'($urandom()) & ((64'd1 << p) - 64'd1));
      // undo the zigzag map
      sval = uval[0] ? ~(uval >> 1) : (uval >> 1);
      return {$urandom(), sval};
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   task automatic note_mismatch(input string what);
      $display("[%0t] ERROR: %s", $time, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: hold each item until transfer, then idle for a random gap
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      pack_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            nxt.cmd   = req_cmd;
            nxt.value = req_value;
            nxt.width = req_width;
            nxt.param = req_rem_bits;
            pack_command(nxt);
            items_accepted++;
            send_gap = pick_gap();
         end
         // slot is free when nothing is offered or the offer just transferred
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cmds_pending.size() > 0) begin
               nxt = cmds_pending.pop_front();
               req_valid    <= 1'b1;
               req_cmd      <= nxt.cmd;
               req_value    <= nxt.value;
               req_width    <= nxt.width;
               req_rem_bits <= nxt.param;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: compare each transfer with the oldest expected byte,
   // then pick the next ready value
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      out_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %02h last %0b error %0b",
                                       rsp_out_byte, rsp_last, rsp_error));
            end else begin
               want = bytes_due.pop_front();
               if (rsp_out_byte !== want.data)
                  note_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, want.data));
               if (rsp_last !== want.last)
                  note_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
               if (rsp_error !== want.err)
                  note_mismatch($sformatf("error %0b, want %0b", rsp_error, want.err));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !hold_off;
            rsp_stall = pick_gap();
         end
      end
   end

   // Long receiver hold-off so the core backs up and stalls its request side
   initial begin : hold_off_proc
      while (items_accepted < 50) @(posedge clock);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned pick;
      int unsigned r;
      int unsigned quo;
      logic [4:0]  p;
      logic [6:0]  w;

      // Directed: field extremes, every command, each corner case
      queue_cmd(rbp_pkg::CMD_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5'd0);   // nothing written
      queue_cmd(rbp_pkg::CMD_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 5'd31);
      queue_cmd(rbp_pkg::CMD_BITS, 64'hA5C3_0F96_5A3C_F069, 7'd127, 5'd0); // clamp to 64
      queue_cmd(rbp_pkg::CMD_BITS, 64'h0000_0000_0000_001F, 7'd5, 5'd0);   // no byte completes
      queue_cmd(rbp_pkg::CMD_WORD, 64'h1122_3344_5566_7788, 7'd4, 5'd0);   // off a byte boundary
      queue_cmd(rbp_pkg::CMD_FLUSH, '0, '0, '0);
      queue_cmd(rbp_pkg::CMD_FLUSH, '0, '0, '0);                           // nothing pending
      queue_cmd(rbp_pkg::CMD_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5'd0);   // zero bytes
      queue_cmd(rbp_pkg::CMD_WORD, 64'h0123_4567_89AB_CDEF, 7'd8, 5'd0);
      queue_cmd(rbp_pkg::CMD_WORD, 64'hFEDC_BA98_7654_3210, 7'd100, 5'd0); // clamp to 8
      queue_cmd(rbp_pkg::CMD_WORD, 64'h0000_0000_0000_0080, 7'd1, 5'd0);
      queue_cmd(rbp_pkg::CMD_UNARY, 64'd0, 7'd0, 5'd0);
      queue_cmd(rbp_pkg::CMD_UNARY, 64'(rbp_pkg::MAX_UNARY), 7'd0, 5'd0);
      queue_cmd(rbp_pkg::CMD_UNARY, 64'(rbp_pkg::MAX_UNARY + 1), 7'd0, 5'd0); // unary overflow
      queue_cmd(rbp_pkg::CMD_UNARY, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5'd0);  // unary overflow
      queue_cmd(rbp_pkg::CMD_RICE, 64'd0, 7'd0, 5'd0);
      queue_cmd(rbp_pkg::CMD_RICE, 64'h0000_0000_8000_0000, 7'd0, 5'd31);  // most negative
      queue_cmd(rbp_pkg::CMD_RICE, 64'hFFFF_FFFF_7FFF_FFFF, 7'd0, 5'd31);  // most positive
      queue_cmd(rbp_pkg::CMD_RICE, 64'd1, 7'd0, 5'd0);
      queue_cmd(rbp_pkg::CMD_RICE, 64'd200, 7'd0, 5'd0);                   // quotient overflow
      queue_cmd(rbp_pkg::CMD_RICE, rice_value(rbp_pkg::MAX_UNARY, 5'd4), 7'd0, 5'd4);
      queue_cmd(rbp_pkg::CMD_RICE, rice_value(rbp_pkg::MAX_UNARY + 1, 5'd2), 7'd0, 5'd2);
      queue_cmd(CMD_FIRST_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 5'd31);
      queue_cmd(CMD_FIRST_UNUSED + 3'd1, '0, 7'd8, 5'd1);
      queue_cmd(CMD_FIRST_UNUSED + 3'd2, 64'd3, 7'd3, 5'd3);

      // Random: mostly well-formed codes with random content, some noise
      n = 0;
      while (n < 145) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            w = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                             : 7'($urandom_range(0, 64));
            queue_cmd(rbp_pkg::CMD_BITS, {$urandom(), $urandom()}, w, 5'($urandom()));
            n++;
         end else if (pick < 42) begin
            r = $urandom_range(0, 19);
            if (r < 15) begin
               queue_cmd(rbp_pkg::CMD_UNARY, 64'($urandom_range(0, 20)), '0, '0);
            end else if (r < 17) begin
               queue_cmd(rbp_pkg::CMD_UNARY,
                         64'($urandom_range(21, rbp_pkg::MAX_UNARY)), '0, '0);
            end else if (r < 19) begin
               queue_cmd(rbp_pkg::CMD_UNARY,
                         64'($urandom_range(rbp_pkg::MAX_UNARY + 1,
                                            rbp_pkg::MAX_UNARY + 40)),
                         '0, '0);
            end else begin
               queue_cmd(rbp_pkg::CMD_UNARY, {$urandom(), $urandom()}, '0, '0);
            end
            n++;
         end else if (pick < 72) begin
            p = 5'($urandom_range(0, 31));
            r = $urandom_range(0, 19);
            quo = (r < 16) ? $urandom_range(0, 12) :
                  (r < 19) ? $urandom_range(13, 60) : $urandom_range(61, rbp_pkg::MAX_UNARY);
            queue_cmd(rbp_pkg::CMD_RICE, rice_value(quo, p), 7'($urandom()), p);
            n++;
         end else if (pick < 77) begin
            queue_cmd(rbp_pkg::CMD_RICE, {$urandom(), $urandom()}, 7'($urandom()),
                      5'($urandom()));
            n++;
         end else if (pick < 89) begin
            // align first half the time so most word writes get through
            if ($urandom_range(0, 1) == 0) queue_cmd(rbp_pkg::CMD_FLUSH, '0, '0, '0);
            w = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, 8));
            queue_cmd(rbp_pkg::CMD_WORD, {$urandom(), $urandom()}, w, 5'($urandom()));
            n++;
         end else if (pick < 97) begin
            queue_cmd(rbp_pkg::CMD_FLUSH, {$urandom(), $urandom()}, 7'($urandom()),
                      5'($urandom()));
            n++;
         end else begin
            queue_cmd(CMD_FIRST_UNUSED + 3'($urandom_range(0, 2)),
                      {$urandom(), $urandom()}, 7'($urandom()), 5'($urandom()));
         end
      end
      // drain the last partial byte
      queue_cmd(rbp_pkg::CMD_FLUSH, '0, '0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < cmds_total) @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      // let any trailing command finish; a stray byte here is still caught
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("rice_bit_packer_core: match");
      end else begin
         $display("rice_bit_packer_core: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #30ms;
      $display("[%0t] ERROR: timeout", $time);
      $display("rice_bit_packer_core: mismatch");
      $finish;
   end

endmodule
